/* rtl/etb_pkg.sv */
// Shared types and constants for the elimination tree builder.
// Used by etb_store, etb_walker and elimination_tree_builder; depends on nothing.
package etb_pkg;

  localparam int FIELD_W   = 10;
  localparam int TDATA_W   = 24;
  localparam int CMP_W     = 17;
  localparam int NODES_DEF = 1024;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] node;
  } anc_entry_t;

endpackage

/* rtl/etb_store.sv */
// Ancestor store: one write port and one read port with a registered read.
// Depends on etb_pkg for the entry type.
module etb_store #(
  parameter int NODES = etb_pkg::NODES_DEF,
  parameter int AW    = $clog2(NODES)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  etb_pkg::anc_entry_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output etb_pkg::anc_entry_t rdata
);

  etb_pkg::anc_entry_t mem [NODES];
  etb_pkg::anc_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/etb_walker.sv */
// Sequencer that clears the ancestor store, then walks and compresses ancestor chains.
// Depends on etb_pkg; drives the ports of one etb_store.
module etb_walker #(
  parameter int NODES = etb_pkg::NODES_DEF,
  parameter int AW    = $clog2(NODES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [etb_pkg::FIELD_W-1:0]  in_col,
  input  logic [etb_pkg::FIELD_W-1:0]  in_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [etb_pkg::FIELD_W-1:0]  out_child,
  output logic [etb_pkg::FIELD_W-1:0]  out_parent,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output etb_pkg::anc_entry_t          mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  etb_pkg::anc_entry_t          mem_rdata
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  localparam logic [etb_pkg::CMP_W-1:0] NODES_LIM = etb_pkg::CMP_W'(NODES);
  localparam logic [AW-1:0]             CLR_LAST  = AW'(NODES - 1);

  logic [1:0]                    state_r, state_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [etb_pkg::FIELD_W-1:0]   col_r, col_nxt;
  logic [etb_pkg::FIELD_W-1:0]   cur_r, cur_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [etb_pkg::FIELD_W-1:0]   out_child_r, out_child_nxt;
  logic [etb_pkg::FIELD_W-1:0]   out_parent_r, out_parent_nxt;
  logic                          accept;
  logic                          start;
  logic                          stall;

  assign accept = in_valid && in_ready;
  assign start  = accept
               && (etb_pkg::CMP_W'(in_col) < NODES_LIM)
               && (etb_pkg::CMP_W'(in_row) < NODES_LIM)
               && (in_row < in_col);
  assign stall  = !mem_rdata.valid && out_valid_r && !out_ready;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    col_nxt        = col_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_child_nxt  = out_child_r;
    out_parent_nxt = out_parent_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = AW'(cur_r);
    mem_wdata      = '{valid: 1'b1, node: col_r};
    mem_re         = 1'b0;
    mem_raddr      = AW'(in_row);
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          mem_re    = 1'b1;
          col_nxt   = in_col;
          cur_nxt   = in_row;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stall) begin
          mem_we = 1'b1;
          if (!mem_rdata.valid) begin
            out_valid_nxt  = 1'b1;
            out_child_nxt  = cur_r;
            out_parent_nxt = col_r;
            state_nxt      = ST_IDLE;
          end else if (mem_rdata.node < col_r) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(mem_rdata.node);
            cur_nxt   = mem_rdata.node;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r        <= col_nxt;
    cur_r        <= cur_nxt;
    out_child_r  <= out_child_nxt;
    out_parent_r <= out_parent_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_child  = out_child_r;
  assign out_parent = out_parent_r;

endmodule

/* rtl/elimination_tree_builder.sv */
// Elimination tree builder: takes upper-triangle nonzeros as (column, row) requests
// and reports each node's parent once found. After reset the ancestor store is
// cleared, one entry per cycle, through all NODES entries; no request is taken
// meanwhile, and each new matrix needs that reset. Columns must arrive in
// nondecreasing order. A request that is out of range or has row >= column is
// accepted and dropped. Any other request walks its ancestor chain, reading the
// store once per node visited; path compression keeps those chains to a few
// nodes on average. A found parent waits in an output register while the next
// request is taken. If another parent is found while that register is still
// full, the walk holds until the register drains.
// Depends on etb_pkg, etb_store and etb_walker.
module elimination_tree_builder #(
  parameter int NODES = etb_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [etb_pkg::TDATA_W-1:0] in_tdata,   // [9:0] column, [19:10] row
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [etb_pkg::TDATA_W-1:0] out_tdata   // [9:0] child, [19:10] parent_node
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  etb_pkg::anc_entry_t         mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  etb_pkg::anc_entry_t         mem_rdata;
  logic [etb_pkg::FIELD_W-1:0] child;
  logic [etb_pkg::FIELD_W-1:0] parent_node;

  etb_walker #(
    .NODES(NODES),
    .AW   (AW)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_col    (in_tdata[9:0]),
    .in_row    (in_tdata[19:10]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_child (child),
    .out_parent(parent_node),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  etb_store #(
    .NODES(NODES),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_tdata = {4'b0000, parent_node, child};

endmodule

/* dv/tb_elimination_tree_builder.sv */
`timescale 1ns / 100ps
// Testbench for elimination_tree_builder: streams upper-triangle (column, row) requests
// and checks every reported (child, parent_node) link against a path-compression model.
// Depends on etb_pkg and the elimination_tree_builder RTL.
module tb_elimination_tree_builder;

  localparam int NODES       = etb_pkg::NODES_DEF;
  localparam int FIELD_W     = etb_pkg::FIELD_W;
  localparam int TDATA_W     = etb_pkg::TDATA_W;
  localparam int WALK_COUNT  = 1100;
  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_WAIT  = 1100;
  localparam int HOLD_CYCLES = 500;

  typedef etb_pkg::anc_entry_t anc_entry_t;

  typedef struct packed {
    logic [FIELD_W-1:0] child;
    logic [FIELD_W-1:0] parent_node;
  } tree_link_t;

  class parent_link_tracker;
    anc_entry_t ancestors [NODES];
    tree_link_t pending_links [$];
    int         errors;

    function new();
      foreach (ancestors[i]) ancestors[i] = '0;
      errors = 0;
    endfunction

    function void record_entry(logic [FIELD_W-1:0] col, logic [FIELD_W-1:0] row);
      int unsigned cur;
      int unsigned steps;
      anc_entry_t  prev;
      tree_link_t  link;
      cur   = row;
      steps = 0;
      if (col >= NODES || row >= NODES) return;
      while (cur < col && steps < NODES) begin
        prev                = ancestors[cur];
        ancestors[cur].valid = 1'b1;
        ancestors[cur].node  = col;
        if (!prev.valid) begin
          link.child       = cur[FIELD_W-1:0];
          link.parent_node = col;
          pending_links.insert(pending_links.size(), link);
          return;
        end
        cur = prev.node;
        steps++;
      end
    endfunction

    function void check_link(logic [TDATA_W-1:0] data);
      tree_link_t want;
      logic [FIELD_W-1:0] got_child;
      logic [FIELD_W-1:0] got_parent;
      got_child  = data[FIELD_W-1:0];
      got_parent = data[2*FIELD_W-1:FIELD_W];
      if (pending_links.size() == 0) begin
        $error("unexpected link: child %0d parent_node %0d", got_child, got_parent);
        errors++;
        return;
      end
      want = pending_links.pop_front();
      if (got_child !== want.child) begin
        $error("child mismatch: expected %0d, actual %0d", want.child, got_child);
        errors++;
      end
      if (got_parent !== want.parent_node) begin
        $error("parent_node mismatch: expected %0d, actual %0d", want.parent_node, got_parent);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_links.size();
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;

  parent_link_tracker links = new();
  int idle_cycles = 0;

  elimination_tree_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [FIELD_W-1:0] col, input logic [FIELD_W-1:0] row,
                              input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W-2*FIELD_W){1'b0}}, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    links.record_entry(col, row);
  endtask

  initial begin : result_sink
    int gap;
    int seen;
    seen = 0;
    forever begin
      gap = ((seen / 90) % 4 == 1) ? 0 : $urandom_range(0, 17);
      if (seen == 120) gap += HOLD_CYCLES;
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      links.check_link(out_tdata);
      seen++;
    end
  end

  initial begin : request_source
    int unsigned col_now;
    int unsigned row;
    int unsigned pick;
    int unsigned span;
    int walks;
    int idx;
    bit burst;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Diagonal, lower-triangle and out-of-order columns, plus the index extremes.
    send_request(10'd0, 10'd0, 1'b0);
    send_request(10'd1, 10'd0, 1'b0);
    send_request(10'd1, 10'd1, 1'b0);
    send_request(10'd0, 10'd1023, 1'b0);
    send_request(10'd2, 10'd1, 1'b0);
    send_request(10'd2, 10'd0, 1'b0);
    send_request(10'd3, 10'd0, 1'b0);
    send_request(10'd5, 10'd3, 1'b0);
    send_request(10'd5, 10'd4, 1'b0);
    send_request(10'd6, 10'd0, 1'b0);
    send_request(10'd4, 10'd1, 1'b0);
    send_request(10'd7, 10'd6, 1'b0);
    send_request(10'd7, 10'd1, 1'b0);
    send_request(10'd1023, 10'd1022, 1'b0);
    send_request(10'd1023, 10'd1023, 1'b0);
    send_request(10'd512, 10'd511, 1'b0);
    send_request(10'h2AA, 10'h155, 1'b0);
    send_request(10'h155, 10'h2AA, 1'b0);
    send_request(10'd8, 10'd7, 1'b0);
    send_request(10'd8, 10'd2, 1'b0);

    col_now = 8;
    walks   = 0;
    idx     = 0;
    while (walks < WALK_COUNT) begin
      burst = ((idx / 100) % 4 == 2);
      pick  = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 4) < 4 && col_now < NODES - 1) col_now++;
        if ($urandom_range(0, 1) == 1) begin
          span = (col_now - 1 < 15) ? col_now - 1 : 15;
          row  = col_now - 1 - $urandom_range(0, span);
        end else begin
          row = $urandom_range(0, col_now - 1);
        end
        send_request(col_now[FIELD_W-1:0], row[FIELD_W-1:0], burst);
        walks++;
      end else if (pick < 90) begin
        row = $urandom_range(col_now, NODES - 1);
        send_request(col_now[FIELD_W-1:0], row[FIELD_W-1:0], burst);
      end else begin
        pick = $urandom_range(0, NODES - 1);
        row  = $urandom_range(0, NODES - 1);
        send_request(pick[FIELD_W-1:0], row[FIELD_W-1:0], burst);
        if (row < pick) walks++;
      end
      idx++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (links.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (links.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/etb_pkg.sv
rtl/etb_store.sv
rtl/etb_walker.sv
rtl/elimination_tree_builder.sv
dv/tb_elimination_tree_builder.sv
